FILE: hdl/first_fit_segment_allocator_assert.svh
// Assertion macros for the first-fit segment allocator.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define FFSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define FFSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and codes for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int unsigned LABEL_W = 8;
    localparam int unsigned BLOCK_W = 16;
    localparam int unsigned OWNER_W = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned USED_W = 5;
    localparam int unsigned CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_PRELOAD = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATE_OK   = 3'd0,
        ST_NO_SPACE    = 3'd1,
        ST_DELETE_OK   = 3'd2,
        ST_DELETE_FAIL = 3'd3,
        ST_PRELOAD_OK  = 3'd4,
        ST_TABLE_FULL  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [BLOCK_W-1:0] first;
        logic [BLOCK_W-1:0] length;
        logic [OWNER_W-1:0] owner;
        logic               has_owner;
    } t_entry;

    // Per-cell command for the update cycle.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE
    } t_op;

    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_cell_ctl;

endpackage

FILE: hdl/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// One table slot: holds an entry, reports gap fit and name match, shifts
// with its neighbors on insert and delete.
// ----------------------------------------------------------------------------
module ffsa_cell
    import ffsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_load,
    input  t_cell_ctl          i_ctl,
    input  logic               i_pos_ge,
    input  logic               i_pos_eq,
    input  logic               i_pos_gt,
    input  t_entry             i_prev,
    input  t_entry             i_next,
    input  logic [BLOCK_W-1:0] i_limit,
    input  logic [BLOCK_W-1:0] i_need,
    input  logic [LABEL_W-1:0] i_name,
    output t_entry             o_entry,
    output logic               o_fit,
    output logic [BLOCK_W-1:0] o_end,
    output logic               o_match
);

    t_entry r_entry;
    t_entry n_entry;
    logic [BLOCK_W:0] w_end;

    assign w_end   = {1'b0, r_entry.first} + {1'b0, r_entry.length};
    assign o_end   = w_end[BLOCK_W-1:0];
    assign o_fit   = ({1'b0, i_limit} >= w_end)
                     && ({1'b0, i_need} <= ({1'b0, i_limit} - w_end));
    assign o_match = (r_entry.label == i_name);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            OP_INSERT: begin
                if (i_pos_eq) begin
                    n_entry = i_ctl.entry;
                end else if (i_pos_gt) begin
                    n_entry = i_prev;
                end
            end
            OP_DELETE: begin
                if (i_pos_ge) begin
                    n_entry = i_next;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= n_entry;
        end
    end

endmodule

FILE: hdl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// Sequencer: latches a transaction, picks the slot from the cell flags,
// drives the shift and holds the result.
// ----------------------------------------------------------------------------
module ffsa_ctrl
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 16,
    parameter int unsigned IDX_W = 4,
    parameter int unsigned CNT_W = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cmd                    i_cmd,
    input  logic [LABEL_W-1:0]      i_name,
    input  logic [BLOCK_W-1:0]      i_count,
    input  logic [BLOCK_W-1:0]      i_start,
    input  logic [OWNER_W-1:0]      i_pid,
    input  logic                    i_priv,
    input  logic [BLOCK_W-1:0]      i_total,
    input  logic [MAX_SEGMENTS-1:0] i_fit,
    input  logic [MAX_SEGMENTS-1:0] i_match,
    input  t_entry                  i_ends [MAX_SEGMENTS],
    input  logic [BLOCK_W-1:0]      i_first0,
    output logic [BLOCK_W-1:0]      o_need,
    output logic [LABEL_W-1:0]      o_name,
    output logic [CNT_W-1:0]        o_count,
    output logic                    o_load,
    output t_cell_ctl               o_ctl,
    output logic [IDX_W-1:0]        o_pos,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic [BLOCK_W-1:0]      o_placed,
    output logic [USED_W-1:0]       o_used
);

    t_state r_state, n_state;
    t_cmd r_cmd;
    logic [LABEL_W-1:0] r_name;
    logic [BLOCK_W-1:0] r_count, r_start;
    logic [OWNER_W-1:0] r_pid;
    logic r_priv;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [BLOCK_W-1:0] r_placed, n_placed;

    logic w_full, w_found, w_hit, w_fit_any;
    logic [IDX_W-1:0] w_hit_idx, w_fit_idx;
    logic [BLOCK_W-1:0] w_fit_end;

    assign o_need  = r_count;
    assign o_name  = r_name;
    assign o_count = r_cnt;
    assign w_full  = (r_cnt >= CNT_W'(MAX_SEGMENTS));

    // First matching name and first fitting gap among valid slots.
    always_comb begin
        w_hit = 1'b0;
        w_hit_idx = '0;
        w_fit_any = 1'b0;
        w_fit_idx = '0;
        for (int k = MAX_SEGMENTS - 1; k >= 0; k--) begin
            if (CNT_W'(k) < r_cnt) begin
                if (i_match[k]) begin
                    w_hit = 1'b1;
                    w_hit_idx = IDX_W'(k);
                end
                if (i_fit[k]) begin
                    w_fit_any = 1'b1;
                    w_fit_idx = IDX_W'(k);
                end
            end
        end
    end

    assign w_fit_end = i_ends[w_fit_idx].first;
    assign w_found = w_hit && (r_priv || (i_ends[w_hit_idx].has_owner
                     && i_ends[w_hit_idx].owner == r_pid));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd   <= i_cmd;
            r_name  <= i_name;
            r_count <= i_count;
            r_start <= i_start;
            r_pid   <= i_pid;
            r_priv  <= i_priv;
        end
        r_status <= n_status;
        r_placed <= n_placed;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_status    = r_status;
        n_placed    = r_placed;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        o_load      = 1'b0;
        o_pos       = '0;
        o_ctl.op    = OP_HOLD;
        o_ctl.entry = '{label: r_name, first: '0, length: r_count,
                        owner: r_pid, has_owner: 1'b1};
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state  = S_OUT;
                n_placed = '0;
                n_status = ST_DELETE_FAIL;
                unique case (r_cmd)
                    CMD_CREATE: begin
                        if (w_full) begin
                            n_status = ST_TABLE_FULL;
                        end else if ((r_cnt == '0 && r_count <= i_total)
                                     || (r_cnt != '0 && r_count <= i_first0)) begin
                            n_status = ST_CREATE_OK;
                            o_load   = 1'b1;
                            o_ctl.op = OP_INSERT;
                            o_pos    = '0;
                            n_cnt    = r_cnt + 1'b1;
                        end else if (r_cnt != '0 && w_fit_any) begin
                            n_status = ST_CREATE_OK;
                            n_placed = w_fit_end;
                            o_load   = 1'b1;
                            o_ctl.op = OP_INSERT;
                            o_ctl.entry.first = w_fit_end;
                            o_pos    = w_fit_idx + 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                        end else begin
                            n_status = ST_NO_SPACE;
                        end
                    end
                    CMD_DELETE: begin
                        if (w_found) begin
                            n_status = ST_DELETE_OK;
                            o_load   = 1'b1;
                            o_ctl.op = OP_DELETE;
                            o_pos    = w_hit_idx;
                            n_cnt    = r_cnt - 1'b1;
                        end
                    end
                    CMD_PRELOAD: begin
                        if (w_full) begin
                            n_status = ST_TABLE_FULL;
                        end else begin
                            n_status = ST_PRELOAD_OK;
                            o_load   = 1'b1;
                            o_ctl.op = OP_INSERT;
                            o_ctl.entry = '{label: r_name, first: r_start,
                                            length: r_count, owner: '0,
                                            has_owner: 1'b0};
                            o_pos    = IDX_W'(r_cnt);
                            n_cnt    = r_cnt + 1'b1;
                        end
                    end
                    default: begin
                        n_status = ST_DELETE_FAIL;
                    end
                endcase
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_status = r_status;
    assign o_placed = r_placed;
    assign o_used   = USED_W'(r_cnt);

endmodule

FILE: hdl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit contiguous segment table built as a row of slot cells.
//
// Channel   Dir  Handshake             Payload
// s_axis    in   s_axis_tvalid/tready  tdata: cmd, file_name, block_count,
//                                            start_block, process_id, privileged
// m_axis    out  m_axis_tvalid/tready  tdata: status, placed_start, segments_used
// cfg       in   i_cfg_valid/o_cfg_ready  total_blocks
//
// A transaction runs through accept, evaluate all cells in parallel and
// shift the row, then present the result until the output is taken.
// Reset empties the table and sets total_blocks to 1024.
// A stalled result holds the block; no new transaction is taken meanwhile.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[1:0], file_name[9:2], block_count[25:10], start_block[41:26],
    // process_id[49:42], privileged[50], zero fill
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[2:0], placed_start[18:3], segments_used[23:19]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic [BLOCK_W-1:0] r_total;
    logic [MAX_SEGMENTS-1:0] w_fit, w_match;
    t_entry w_ent [MAX_SEGMENTS];
    logic [BLOCK_W-1:0] w_end [MAX_SEGMENTS];
    logic [BLOCK_W-1:0] w_need;
    logic [LABEL_W-1:0] w_name;
    logic [CNT_W-1:0] w_cnt;
    logic w_load;
    t_cell_ctl w_ctl;
    logic [IDX_W-1:0] w_pos;
    t_entry w_endrec [MAX_SEGMENTS];
    logic [STATUS_W-1:0] w_status;
    logic [BLOCK_W-1:0] w_placed;
    logic [USED_W-1:0] w_used;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= 16'd1024;
        end else if (i_cfg_valid) begin
            r_total <= i_cfg_data;
        end
    end

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        t_entry w_prev, w_next;
        logic [BLOCK_W-1:0] w_limit;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_ent[g-1];
        end
        if (g == MAX_SEGMENTS - 1) begin : g_last
            assign w_next  = '0;
            assign w_limit = r_total;
        end else begin : g_inner
            assign w_next  = w_ent[g+1];
            assign w_limit = (CNT_W'(g + 1) < w_cnt) ? w_ent[g+1].first : r_total;
        end
        // Carry end address in the first field for the sequencer.
        assign w_endrec[g] = '{label: '0, first: w_end[g], length: '0,
                               owner: w_ent[g].owner, has_owner: w_ent[g].has_owner};

        ffsa_cell u_cell (
            .i_clk   (i_clk),
            .i_load  (w_load),
            .i_ctl   (w_ctl),
            .i_pos_ge(IDX_W'(g) >= w_pos),
            .i_pos_eq(IDX_W'(g) == w_pos),
            .i_pos_gt(IDX_W'(g) > w_pos),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_limit (w_limit),
            .i_need  (w_need),
            .i_name  (w_name),
            .o_entry (w_ent[g]),
            .o_fit   (w_fit[g]),
            .o_end   (w_end[g]),
            .o_match (w_match[g])
        );
    end

    ffsa_ctrl #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_cmd      (t_cmd'(s_axis_tdata[1:0])),
        .i_name     (s_axis_tdata[9:2]),
        .i_count    (s_axis_tdata[25:10]),
        .i_start    (s_axis_tdata[41:26]),
        .i_pid      (s_axis_tdata[49:42]),
        .i_priv     (s_axis_tdata[50]),
        .i_total    (r_total),
        .i_fit      (w_fit),
        .i_match    (w_match),
        .i_ends     (w_endrec),
        .i_first0   (w_ent[0].first),
        .o_need     (w_need),
        .o_name     (w_name),
        .o_count    (w_cnt),
        .o_load     (w_load),
        .o_ctl      (w_ctl),
        .o_pos      (w_pos),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_status   (w_status),
        .o_placed   (w_placed),
        .o_used     (w_used)
    );

    assign m_axis_tdata = {w_used, w_placed, w_status};

endmodule

FILE: hdl/ffsa_checker.sv
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks for the first-fit segment allocator.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_assert.svh"

module ffsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    `FFSA_ASSERT_SAME(a_no_overlap, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `FFSA_ASSERT_NEXT(a_accept_no_ready, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready && !m_axis_tvalid, "busy slip")
    `FFSA_ASSERT_SAME(a_status_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[2:0] <= 3'd5, "bad status")
    `FFSA_ASSERT_SAME(a_placed_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[2:0] != 3'd0, m_axis_tdata[18:3] == 16'd0, "placed nonzero")
    `FFSA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
